### rtl/core/sbpa_pkg.sv
package sbpa_pkg;

    localparam int SLABS_DEFAULT     = 16;
    localparam int MAX_SLOTS_DEFAULT = 64;
    localparam int CNT_W             = 11;
    localparam logic [CNT_W-1:0] CNT_MAX = 11'd2047;
    localparam int CFG_W             = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef enum logic [1:0]
    {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_DOUBLE  = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic
    {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_CLEAR,
        S_READ,
        S_MODIFY,
        S_RESULT
    } state_t;

endpackage

### rtl/core/slab_bitmap_pool_allocator.sv
// slab bitmap pool allocator
// input channel s_axis_*: one request per transaction, tdata holds operation,
// slab_index, item_index from bit 0 up, padded to 16 bits. operation 0
// allocates an item, 1 frees slab_index/item_index.
// output channel m_axis_*: one result per request, tdata holds status,
// granted_slab, granted_slot, items_in_use, peak_in_use from bit 0 up, 40 bits.
// cfg_*: writes items_per_slab (clamped to 1..MAX_SLOTS); write only while
// idle.
// after reset a clearing pass zeroes every row of the occupancy memory;
// no request is taken during it.
// after the accepting edge a request passes the read of the occupancy memory
// (the row is registered), modify and write back, then the result register.
// slab selection uses a rank scan over flip-flop ranks and counts; the bitmap
// row goes through a priority encoder.
// a result holds in the output register while m_axis_tready is low; the next
// request is accepted only once the result has been taken.
module slab_bitmap_pool_allocator #(
    parameter int SLABS     = sbpa_pkg::SLABS_DEFAULT,
    parameter int MAX_SLOTS = sbpa_pkg::MAX_SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // operation, slab_index[3:0], item_index[5:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // status[1:0], granted_slab[3:0], granted_slot[5:0],
                                       // items_in_use[10:0], peak_in_use[10:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    localparam int SW  = (SLABS > 1) ? $clog2(SLABS) : 1;
    localparam int AW  = $clog2(SLABS + 1);
    localparam int IW  = $clog2(MAX_SLOTS);
    localparam int UW  = $clog2(MAX_SLOTS + 1);
    localparam int CW  = sbpa_pkg::CNT_W;

    sbpa_pkg::state_t state_reg, state_next;

    logic [MAX_SLOTS-1:0] occ_mem [SLABS];
    logic [MAX_SLOTS-1:0] rd_data_reg;

    logic [UW-1:0] cnt_reg  [SLABS];
    logic [SW-1:0] rank_reg [SLABS];
    logic [AW-1:0] active_reg;
    logic [sbpa_pkg::CNT_W-1:0] total_reg, peak_reg;
    logic [sbpa_pkg::CFG_W-1:0] ipsl_reg;
    logic [SW-1:0] clr_reg;

    logic          op_reg;
    logic [5:0]    ii_reg;
    logic [SW-1:0] sel_reg;
    logic          sel_ok_reg;
    logic          inval_reg;
    logic          new_slab_reg;

    logic [1:0]    o_status_reg;
    logic [3:0]    o_slab_reg;
    logic [5:0]    o_slot_reg;
    logic          o_valid_reg;

    // clamped capacity
    logic [UW-1:0] cap;
    always_comb
    begin
        if (ipsl_reg == '0)
            cap = UW'(1);
        else if ({1'b0, ipsl_reg} > 8'(MAX_SLOTS))
            cap = UW'(MAX_SLOTS);
        else
            cap = UW'(ipsl_reg);
    end

    // head of partial and empty lists
    logic [SW-1:0] ph, eh;
    logic          pf, ef;
    always_comb
    begin
        ph = '0; eh = '0; pf = 1'b0; ef = 1'b0;
        for (int s = 0; s < SLABS; s++)
        begin
            if (AW'(s) < active_reg)
            begin
                if (cnt_reg[s] == '0)
                begin
                    if (!ef || rank_reg[s] < rank_reg[eh])
                    begin
                        eh = SW'(s); ef = 1'b1;
                    end
                end
                else if (cnt_reg[s] < cap)
                begin
                    if (!pf || rank_reg[s] < rank_reg[ph])
                    begin
                        ph = SW'(s); pf = 1'b1;
                    end
                end
            end
        end
    end

    // first clear slot within capacity
    logic [IW-1:0] fz;
    logic          fz_ok;
    always_comb
    begin
        fz = '0; fz_ok = 1'b0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--)
        begin
            if (UW'(i) < cap && !rd_data_reg[i])
            begin
                fz = IW'(i); fz_ok = 1'b1;
            end
        end
    end

    logic [IW-1:0] ii_w;
    assign ii_w = IW'(ii_reg);

    logic in_fire;
    assign s_axis_tready = (state_reg == sbpa_pkg::S_IDLE) && !o_valid_reg;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sbpa_pkg::S_CLEAR:  if (clr_reg == SW'(SLABS - 1)) state_next = sbpa_pkg::S_IDLE;
            sbpa_pkg::S_IDLE:   if (in_fire) state_next = sbpa_pkg::S_READ;
            sbpa_pkg::S_READ:   state_next = sbpa_pkg::S_MODIFY;
            sbpa_pkg::S_MODIFY: state_next = sbpa_pkg::S_RESULT;
            sbpa_pkg::S_RESULT: state_next = sbpa_pkg::S_IDLE;
            default:            state_next = sbpa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sbpa_pkg::S_CLEAR;
        else
            state_reg <= state_next;
    end

    // occupancy memory: one read port, one write port
    logic [MAX_SLOTS-1:0] wr_row;
    logic                 wr_en;
    logic [SW-1:0]        wr_addr;
    always_ff @(posedge clk)
    begin
        if (wr_en)
            occ_mem[wr_addr] <= wr_row;
        if (state_reg == sbpa_pkg::S_READ)
            rd_data_reg <= occ_mem[sel_reg];
    end

    // modify stage decisions
    logic do_alloc, do_free, fr_bit;
    assign fr_bit   = rd_data_reg[ii_w];
    assign do_alloc = (op_reg == sbpa_pkg::OP_ALLOC) && sel_ok_reg && fz_ok;
    assign do_free  = (op_reg == sbpa_pkg::OP_FREE) && !inval_reg && fr_bit;

    always_comb
    begin
        wr_en = 1'b0; wr_addr = sel_reg; wr_row = rd_data_reg;
        if (state_reg == sbpa_pkg::S_CLEAR)
        begin
            wr_en = 1'b1; wr_addr = clr_reg; wr_row = '0;
        end
        else if (state_reg == sbpa_pkg::S_MODIFY)
        begin
            if (do_alloc)
            begin
                wr_en = 1'b1; wr_row[fz] = 1'b1;
            end
            else if (do_free)
            begin
                wr_en = 1'b1; wr_row[ii_w] = 1'b0;
            end
        end
    end

    // move-to-front bookkeeping for the modify stage
    logic [UW-1:0] cnt_cur, cnt_new;
    logic          mf1, mf2;
    always_comb
    begin
        cnt_cur = cnt_reg[sel_reg];
        cnt_new = cnt_cur;
        mf1 = 1'b0; mf2 = 1'b0;
        if (do_alloc)
        begin
            cnt_new = cnt_cur + UW'(1);
            mf1 = new_slab_reg;
            mf2 = (cnt_new >= cap);
        end
        else if (do_free)
        begin
            mf1 = (cnt_cur >= cap);
            if (cnt_cur != '0) cnt_new = cnt_cur - UW'(1);
            mf2 = (cnt_new == '0);
        end
    end

    logic [SW-1:0] rank_mid [SLABS];
    logic [SW-1:0] rank_fin [SLABS];
    always_comb
    begin
        for (int t = 0; t < SLABS; t++)
        begin
            rank_mid[t] = rank_reg[t];
            if (mf1 && rank_reg[t] < rank_reg[sel_reg]) rank_mid[t] = rank_reg[t] + SW'(1);
        end
        if (mf1) rank_mid[sel_reg] = '0;
        for (int t = 0; t < SLABS; t++)
        begin
            rank_fin[t] = rank_mid[t];
            if (mf2 && rank_mid[t] < rank_mid[sel_reg]) rank_fin[t] = rank_mid[t] + SW'(1);
        end
        if (mf2) rank_fin[sel_reg] = '0;
    end

    logic [sbpa_pkg::CNT_W-1:0] total_new, peak_new;
    always_comb
    begin
        total_new = total_reg;
        if (do_alloc && total_reg != sbpa_pkg::CNT_MAX) total_new = total_reg + CW'(1);
        if (do_free && total_reg != '0) total_new = total_reg - CW'(1);
        peak_new = (total_new > peak_reg) ? total_new : peak_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLABS; s++)
            begin
                cnt_reg[s]  <= '0;
                rank_reg[s] <= SW'(s);
            end
            active_reg   <= '0;
            total_reg    <= '0;
            peak_reg     <= '0;
            ipsl_reg     <= sbpa_pkg::CFG_RESET;
            clr_reg      <= '0;
            o_valid_reg  <= 1'b0;
            sel_ok_reg   <= 1'b0;
            new_slab_reg <= 1'b0;
            op_reg       <= 1'b0;
            ii_reg       <= '0;
            sel_reg      <= '0;
            inval_reg    <= 1'b0;
            o_status_reg <= '0;
            o_slab_reg   <= '0;
            o_slot_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready) ipsl_reg <= cfg_data;
            if (state_reg == sbpa_pkg::S_CLEAR) clr_reg <= clr_reg + SW'(1);
            if (in_fire)
            begin
                op_reg <= s_axis_tdata[0];
                ii_reg <= s_axis_tdata[10:5];
                if (s_axis_tdata[0] == sbpa_pkg::OP_FREE)
                begin
                    sel_reg      <= SW'(s_axis_tdata[4:1]);
                    sel_ok_reg   <= 1'b1;
                    new_slab_reg <= 1'b0;
                    inval_reg    <= (int'(s_axis_tdata[4:1]) >= int'(active_reg))
                                 || (int'(s_axis_tdata[10:5]) >= int'(cap));
                end
                else
                begin
                    inval_reg <= 1'b0;
                    if (pf)
                    begin
                        sel_reg <= ph; sel_ok_reg <= 1'b1; new_slab_reg <= 1'b0;
                    end
                    else if (ef)
                    begin
                        sel_reg <= eh; sel_ok_reg <= 1'b1; new_slab_reg <= 1'b1;
                    end
                    else if (active_reg < AW'(SLABS))
                    begin
                        sel_reg <= SW'(active_reg); sel_ok_reg <= 1'b1;
                        new_slab_reg <= 1'b1;
                        active_reg <= active_reg + AW'(1);
                    end
                    else
                    begin
                        sel_reg <= '0; sel_ok_reg <= 1'b0; new_slab_reg <= 1'b0;
                    end
                end
            end
            if (state_reg == sbpa_pkg::S_MODIFY)
            begin
                cnt_reg[sel_reg] <= cnt_new;
                for (int t = 0; t < SLABS; t++)
                    rank_reg[t] <= rank_fin[t];
                total_reg <= total_new;
                peak_reg  <= peak_new;
                o_slab_reg <= do_alloc ? 4'(sel_reg) : 4'd0;
                o_slot_reg <= do_alloc ? 6'(fz) : 6'd0;
                if (op_reg == sbpa_pkg::OP_ALLOC)
                    o_status_reg <= do_alloc ? sbpa_pkg::ST_OK : sbpa_pkg::ST_NOSPACE;
                else if (inval_reg)
                    o_status_reg <= sbpa_pkg::ST_INVALID;
                else if (!fr_bit)
                    o_status_reg <= sbpa_pkg::ST_DOUBLE;
                else
                    o_status_reg <= sbpa_pkg::ST_OK;
            end
            if (state_reg == sbpa_pkg::S_RESULT)
                o_valid_reg <= 1'b1;
            else if (m_axis_tvalid && m_axis_tready)
                o_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = {1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, peak_reg, total_reg,
                            o_slot_reg, o_slab_reg, o_status_reg};

    assert property (@(posedge clk) disable iff (!rst_n) peak_reg >= total_reg)
        else $error("peak below in-use count");
    assert property (@(posedge clk) disable iff (!rst_n) active_reg <= AW'(SLABS))
        else $error("active slab count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sbpa_pkg::S_MODIFY) |=> (state_reg == sbpa_pkg::S_RESULT))
        else $error("modify not followed by result");
    assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid_reg && !m_axis_tready) |=> $stable(o_status_reg))
        else $error("result changed while stalled");

endmodule

### bench/slab_bitmap_pool_allocator_tb.sv
module slab_bitmap_pool_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLAB = 16;
    localparam int NSLOT = 64;

    typedef struct packed
    {
        logic [5:0]    item;
        logic [3:0]    slab;
        sbpa_pkg::op_t op;
    } request_t;

    typedef struct packed
    {
        logic [10:0]       peak;
        logic [10:0]       in_use;
        logic [5:0]        slot;
        logic [3:0]        slab;
        sbpa_pkg::status_t status;
    } grant_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;

    slab_bitmap_pool_allocator u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // allocator shadow state
    logic [6:0]  slots_cfg;
    logic [63:0] occ [NSLAB];
    logic [6:0]  fill [NSLAB];
    logic [3:0]  rank [NSLAB];
    int          n_active;
    logic [10:0] in_use_cnt;
    logic [10:0] peak_cnt;

    request_t pending_reqs [$];
    grant_t   expected_grants [$];
    int       errors;
    int       stall_hold;
    int       gap_left;
    int       burst_left;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int slab_cap();
        int c;
        c = slots_cfg;
        if (c < 1)
            c = 1;
        if (c > NSLOT)
            c = NSLOT;
        return c;
    endfunction

    task automatic to_front(input int s);
        logic [3:0] old;
        old = rank[s];
        for (int t = 0; t < NSLAB; t++)
            if (rank[t] < old)
                rank[t]++;
        rank[s] = 0;
    endtask

    function automatic int head_of(input bit partial, input int cap);
        int best;
        best = NSLAB;
        for (int s = 0; s < n_active; s++)
        begin
            if ((partial ? (fill[s] > 0 && fill[s] < cap) : (fill[s] == 0)) &&
                (best == NSLAB || rank[s] < rank[best]))
                best = s;
        end
        return best;
    endfunction

    task automatic predict_grant(input request_t r);
        grant_t g;
        int cap;
        int s;
        int found;
        g = '0;
        g.status = sbpa_pkg::ST_OK;
        cap = slab_cap();
        if (r.op == sbpa_pkg::OP_ALLOC)
        begin
            s = head_of(1'b1, cap);
            if (s == NSLAB)
            begin
                s = head_of(1'b0, cap);
                if (s == NSLAB && n_active < NSLAB)
                begin
                    s = n_active;
                    n_active++;
                end
                if (s != NSLAB)
                    to_front(s);
            end
            found = NSLOT;
            if (s != NSLAB)
                for (int i = cap - 1; i >= 0; i--)
                    if (!occ[s][i])
                        found = i;
            if (s == NSLAB || found == NSLOT)
                g.status = sbpa_pkg::ST_NOSPACE;
            else
            begin
                occ[s][found] = 1'b1;
                fill[s]++;
                if (fill[s] >= cap)
                    to_front(s);
                if (in_use_cnt < sbpa_pkg::CNT_MAX)
                    in_use_cnt++;
                if (in_use_cnt > peak_cnt)
                    peak_cnt = in_use_cnt;
                g.slab = s[3:0];
                g.slot = found[5:0];
            end
        end
        else if (r.slab >= n_active || r.item >= cap)
            g.status = sbpa_pkg::ST_INVALID;
        else if (!occ[r.slab][r.item])
            g.status = sbpa_pkg::ST_DOUBLE;
        else
        begin
            occ[r.slab][r.item] = 1'b0;
            if (fill[r.slab] >= cap)
                to_front(r.slab);
            if (fill[r.slab] > 0)
                fill[r.slab]--;
            if (fill[r.slab] == 0)
                to_front(r.slab);
            if (in_use_cnt > 0)
                in_use_cnt--;
        end
        g.in_use = in_use_cnt;
        g.peak = peak_cnt;
        expected_grants.push_back(g);
    endtask

    task automatic report(input string what, input logic [39:0] got, input logic [39:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // driver: bursts and gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            gap_left      <= 0;
            burst_left    <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                predict_grant(request_t'(s_axis_tdata[10:0]));
            if (s_axis_tvalid)
                void'(pending_reqs.pop_front());
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {5'd0, pending_reqs[0]};
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(12, 1);
                    gap_left   <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 0);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // monitor with its own stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_grants.size() == 0)
                    report("unexpected", m_axis_tdata, '0);
                else
                begin
                    grant_t w;
                    grant_t g;
                    w = expected_grants.pop_front();
                    g = grant_t'(m_axis_tdata[33:0]);
                    if (g.status !== w.status)
                        report("status", g.status, w.status);
                    if (g.slab !== w.slab)
                        report("granted_slab", g.slab, w.slab);
                    if (g.slot !== w.slot)
                        report("granted_slot", g.slot, w.slot);
                    if (g.in_use !== w.in_use)
                        report("items_in_use", g.in_use, w.in_use);
                    if (g.peak !== w.peak)
                        report("peak_in_use", g.peak, w.peak);
                end
            end
            if (stall_hold > 0)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= ($urandom_range(3, 0) != 0);
        end
    end

    task automatic add_req(input sbpa_pkg::op_t op, input int slab, input int item);
        request_t r;
        r.op = op;
        r.slab = slab[3:0];
        r.item = item[5:0];
        pending_reqs.push_back(r);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_grants.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [6:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        slots_cfg = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int n, input int free_pct);
        int cap;
        cap = slab_cap();
        for (int i = 0; i < n; i++)
        begin
            int k;
            k = $urandom_range(99, 0);
            if (k < 100 - free_pct)
                add_req(sbpa_pkg::OP_ALLOC, $urandom_range(15, 0), $urandom_range(63, 0));
            else if (k < 95)
                add_req(sbpa_pkg::OP_FREE, $urandom_range(15, 0), $urandom_range(cap - 1, 0));
            else
                add_req(sbpa_pkg::OP_FREE, $urandom_range(15, 0), $urandom_range(63, 0));
        end
    endtask

    initial
    begin
        errors = 0;
        stall_hold = 0;
        slots_cfg = sbpa_pkg::CFG_RESET;
        for (int s = 0; s < NSLAB; s++)
        begin
            occ[s] = '0;
            fill[s] = '0;
            rank[s] = s[3:0];
        end
        n_active = 0;
        in_use_cnt = '0;
        peak_cnt = '0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: minimum capacity, exhaust all slabs, errors
        write_cfg(7'd1);
        add_req(sbpa_pkg::OP_FREE, 0, 0);
        for (int i = 0; i < 17; i++)
            add_req(sbpa_pkg::OP_ALLOC, 15, 63);
        add_req(sbpa_pkg::OP_FREE, 15, 0);
        add_req(sbpa_pkg::OP_FREE, 15, 0);
        add_req(sbpa_pkg::OP_FREE, 3, 1);
        add_req(sbpa_pkg::OP_FREE, 0, 63);
        add_req(sbpa_pkg::OP_ALLOC, 0, 0);
        drain();

        // zero clamps to one, long receiver hold
        write_cfg(7'd0);
        random_phase(40, 40);
        stall_hold = 1;
        repeat (60) @(posedge clk);
        stall_hold = 0;
        drain();

        write_cfg(7'd127);
        random_phase(120, 25);
        drain();

        // lower capacity under occupied slabs
        write_cfg(7'd3);
        random_phase(80, 45);
        drain();

        write_cfg(7'd64);
        random_phase(100, 35);
        drain();

        write_cfg(7'd7);
        random_phase(80, 50);
        drain();

        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

### filelist.f
rtl/core/sbpa_pkg.sv
rtl/core/slab_bitmap_pool_allocator.sv
bench/slab_bitmap_pool_allocator_tb.sv
